// ----- src/fcfs_pkg.sv -----
`timescale 1ns / 1ps

package fcfs_pkg;

   // Default sizing of the job store and of the time fields
   localparam int MAX_PROCESSES_DEF = 16;
   localparam int TIME_BITS_DEF     = 16;

   // Fixed transaction field widths
   localparam int ARRIVAL_W    = 16;
   localparam int BURST_W      = 16;
   localparam int JOB_INDEX_W  = 4;
   localparam int COMPLETION_W = 21;
   localparam int TURNAROUND_W = 20;
   localparam int WAITING_W    = 20;
   localparam int TOTAL_W      = 24;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_DRAIN,
      ST_CALC,
      ST_EMIT
   } fsm_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic scan_rd;
      logic calc;
      logic emit;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_last;
      logic out_free;
      logic final_res;
   } dp_status_type;

   typedef struct packed {
      logic [JOB_INDEX_W-1:0]  job_index;
      logic [COMPLETION_W-1:0] completion;
      logic [TURNAROUND_W-1:0] turnaround;
      logic [WAITING_W-1:0]    waiting;
      logic [TOTAL_W-1:0]      total_turnaround;
      logic [TOTAL_W-1:0]      total_waiting;
      logic                    last_result;
   } rsp_payload_type;

endpackage

// ----- src/fcfs_intf.sv -----
`timescale 1ns / 1ps

interface fcfs_req_if;
   import fcfs_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [ARRIVAL_W-1:0] arrival;
   logic [BURST_W-1:0]   burst;
   logic                 last_job;

   modport source (output valid, output arrival, output burst, output last_job, input ready);
   modport sink   (input valid, input arrival, input burst, input last_job, output ready);
endinterface

interface fcfs_rsp_if;
   import fcfs_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [JOB_INDEX_W-1:0]  job_index;
   logic [COMPLETION_W-1:0] completion;
   logic [TURNAROUND_W-1:0] turnaround;
   logic [WAITING_W-1:0]    waiting;
   logic [TOTAL_W-1:0]      total_turnaround;
   logic [TOTAL_W-1:0]      total_waiting;
   logic                    last_result;

   modport source (
      output valid, output job_index, output completion, output turnaround,
      output waiting, output total_turnaround, output total_waiting,
      output last_result, input ready
   );
   modport sink (
      input valid, input job_index, input completion, input turnaround,
      input waiting, input total_turnaround, input total_waiting,
      input last_result, output ready
   );
endinterface

// ----- src/fcfs_ctrl.sv -----
`timescale 1ns / 1ps

module fcfs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_last_job,
   output logic                     req_ready,
   input  fcfs_pkg::dp_status_type  status,
   output fcfs_pkg::dp_cmd_type     cmd
);
   import fcfs_pkg::*;

   fsm_state_type state_ff;
   fsm_state_type state_in;

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequence loading, scanning, timing and emitting
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last_job) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last read is compared in this cycle
            state_in = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.final_res ? ST_LOAD : ST_SCAN;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

// ----- src/fcfs_dpath.sv -----
`timescale 1ns / 1ps

module fcfs_dpath #(
   parameter int MAX_PROCESSES = fcfs_pkg::MAX_PROCESSES_DEF,
   parameter int TIME_BITS     = fcfs_pkg::TIME_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  fcfs_pkg::dp_cmd_type              cmd,
   output fcfs_pkg::dp_status_type           status,
   input  logic [fcfs_pkg::ARRIVAL_W-1:0]    arrival,
   input  logic [fcfs_pkg::BURST_W-1:0]      burst,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output fcfs_pkg::rsp_payload_type         rsp_data
);
   import fcfs_pkg::*;

   localparam int IDX_W   = $clog2(MAX_PROCESSES);
   localparam int CNT_W   = $clog2(MAX_PROCESSES + 1);
   localparam int CLK_W   = TIME_BITS + $clog2(MAX_PROCESSES) + 1;
   localparam int ENTRY_W = 2 * TIME_BITS;

   logic [ENTRY_W-1:0]       job_mem [MAX_PROCESSES];
   logic [ENTRY_W-1:0]       mem_q_ff;

   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         res_count_ff, res_count_in;
   logic [IDX_W-1:0]         scan_idx_ff, scan_idx_in;
   logic                     rd_valid_ff;
   logic [IDX_W-1:0]         rd_idx_ff;
   logic                     found_ff, found_in;
   logic [TIME_BITS-1:0]     best_arr_ff, best_arr_in;
   logic [TIME_BITS-1:0]     best_bur_ff, best_bur_in;
   logic [IDX_W-1:0]         best_idx_ff, best_idx_in;
   logic [MAX_PROCESSES-1:0] served_ff, served_in;
   logic [CLK_W-1:0]         clock_ff, clock_in;
   logic [CLK_W-1:0]         start_ff, start_in;
   logic [TOTAL_W-1:0]       sum_tat_ff, sum_tat_in;
   logic [TOTAL_W-1:0]       sum_wt_ff, sum_wt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_payload_type          rsp_data_ff, rsp_data_in;

   logic [TIME_BITS-1:0]     arr_t, bur_t;
   logic [TIME_BITS-1:0]     q_arr, q_bur;
   logic                     full;
   logic [CLK_W-1:0]         best_arr_w;
   logic [CLK_W-1:0]         start_w;
   logic [CLK_W-1:0]         tat_w;
   logic [CLK_W-1:0]         wt_w;

   assign arr_t      = TIME_BITS'(arrival);
   assign bur_t      = TIME_BITS'(burst);
   assign q_arr      = mem_q_ff[ENTRY_W-1:TIME_BITS];
   assign q_bur      = mem_q_ff[TIME_BITS-1:0];
   assign full       = (count_ff == CNT_W'(MAX_PROCESSES));
   assign best_arr_w = CLK_W'(best_arr_ff);
   assign start_w    = (clock_ff > best_arr_w) ? clock_ff : best_arr_w;
   assign tat_w      = clock_ff - best_arr_w;
   assign wt_w       = start_ff - best_arr_w;

   assign status.scan_last = ((CNT_W'(scan_idx_ff) + CNT_W'(1)) == count_ff);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign status.final_res = ((res_count_ff + CNT_W'(1)) == count_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Job store: write at the fill position, read one entry per scan cycle
   always_ff @(posedge clock) begin
      if (cmd.load && !full) begin
         job_mem[count_ff[IDX_W-1:0]] <= {arr_t, bur_t};
      end
      if (cmd.scan_rd) begin
         mem_q_ff <= job_mem[scan_idx_ff];
      end
   end

   always_comb begin
      count_in     = count_ff;
      res_count_in = res_count_ff;
      scan_idx_in  = scan_idx_ff;
      found_in     = found_ff;
      best_arr_in  = best_arr_ff;
      best_bur_in  = best_bur_ff;
      best_idx_in  = best_idx_ff;
      served_in    = served_ff;
      clock_in     = clock_ff;
      start_in     = start_ff;
      sum_tat_in   = sum_tat_ff;
      sum_wt_in    = sum_wt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      // Advance the fill count; drop a job once the store is full
      if (cmd.load && !full) begin
         count_in = count_ff + CNT_W'(1);
      end

      // Advance the scan address
      if (cmd.scan_rd) begin
         scan_idx_in = scan_idx_ff + IDX_W'(1);
      end

      // Keep the earliest unserved job; strict compare keeps the lowest index on ties
      if (rd_valid_ff && !served_ff[rd_idx_ff] && (!found_ff || q_arr < best_arr_ff)) begin
         found_in    = 1'b1;
         best_arr_in = q_arr;
         best_bur_in = q_bur;
         best_idx_in = rd_idx_ff;
      end

      // Start at arrival if idle, then run the burst; rearm the scan
      if (cmd.calc) begin
         start_in    = start_w;
         clock_in    = start_w + CLK_W'(best_bur_ff);
         scan_idx_in = '0;
         found_in    = 1'b0;
      end

      // Load the result register and update the running totals
      if (cmd.emit) begin
         sum_tat_in                   = sum_tat_ff + TOTAL_W'(tat_w);
         sum_wt_in                    = sum_wt_ff + TOTAL_W'(wt_w);
         rsp_valid_in                 = 1'b1;
         rsp_data_in.job_index        = JOB_INDEX_W'(best_idx_ff);
         rsp_data_in.completion       = COMPLETION_W'(clock_ff);
         rsp_data_in.turnaround       = TURNAROUND_W'(tat_w);
         rsp_data_in.waiting          = WAITING_W'(wt_w);
         rsp_data_in.total_turnaround = sum_tat_in;
         rsp_data_in.total_waiting    = sum_wt_in;
         rsp_data_in.last_result      = status.final_res;
         served_in[best_idx_ff]       = 1'b1;
         res_count_in                 = res_count_ff + CNT_W'(1);
         // Clear the set after its final job
         if (status.final_res) begin
            count_in     = '0;
            res_count_in = '0;
            served_in    = '0;
            clock_in     = '0;
            sum_tat_in   = '0;
            sum_wt_in    = '0;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         res_count_ff <= '0;
         scan_idx_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         served_ff    <= '0;
         clock_ff     <= '0;
         sum_tat_ff   <= '0;
         sum_wt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         res_count_ff <= res_count_in;
         scan_idx_ff  <= scan_idx_in;
         rd_valid_ff  <= cmd.scan_rd;
         found_ff     <= found_in;
         served_ff    <= served_in;
         clock_ff     <= clock_in;
         sum_tat_ff   <= sum_tat_in;
         sum_wt_ff    <= sum_wt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      rd_idx_ff   <= scan_idx_ff;
      best_arr_ff <= best_arr_in;
      best_bur_ff <= best_bur_in;
      best_idx_ff <= best_idx_in;
      start_ff    <= start_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- src/fcfs_schedule_timing.sv -----
`timescale 1ns / 1ps
// Channel    Dir  Handshake      Payload
// req_chan   in   valid/ready    arrival, burst, last_job
// rsp_chan   out  valid/ready    job_index, completion, turnaround, waiting,
//                                total_turnaround, total_waiting, last_result
//
// Jobs load back to back. After the job marked last, each result takes N reads
// of the single-port job store for N held jobs to find the earliest unserved
// arrival, then one compare drain, one time update and one emit.
// Reset is synchronous and clears all control state; the store needs no clearing.
// An emit waits while the result register holds an untaken transaction; no new
// job is taken until the last result of the set is in the result register.

module fcfs_schedule_timing #(
   parameter int MAX_PROCESSES = fcfs_pkg::MAX_PROCESSES_DEF,
   parameter int TIME_BITS     = fcfs_pkg::TIME_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   fcfs_req_if.sink   req_chan,
   fcfs_rsp_if.source rsp_chan
);
   import fcfs_pkg::*;

   dp_cmd_type      cmd;
   dp_status_type   status;
   rsp_payload_type rsp_data;

   fcfs_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .req_last_job (req_chan.last_job),
      .req_ready    (req_chan.ready),
      .status       (status),
      .cmd          (cmd)
   );

   fcfs_dpath #(
      .MAX_PROCESSES (MAX_PROCESSES),
      .TIME_BITS     (TIME_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .arrival   (req_chan.arrival),
      .burst     (req_chan.burst),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_data  (rsp_data)
   );

   // Drive the result channel from the result register
   assign rsp_chan.job_index        = rsp_data.job_index;
   assign rsp_chan.completion       = rsp_data.completion;
   assign rsp_chan.turnaround       = rsp_data.turnaround;
   assign rsp_chan.waiting          = rsp_data.waiting;
   assign rsp_chan.total_turnaround = rsp_data.total_turnaround;
   assign rsp_chan.total_waiting    = rsp_data.total_waiting;
   assign rsp_chan.last_result      = rsp_data.last_result;

endmodule

// ----- src/fcfs_chk.sv -----
`timescale 1ns / 1ps

module fcfs_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              req_last_job,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_last_result,
   input logic [fcfs_pkg::COMPLETION_W-1:0] rsp_completion
);

   // A stalled result transaction keeps its completion time
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_completion))
      else $error("stalled result transaction changed");

   // The last job of a set closes the input until scheduling ends
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_job |=> !req_ready)
      else $error("job accepted after last job of set");

   // No job is taken while a set still has results to come
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |-> !req_ready)
      else $error("input open while results pending");

   // Reset empties the result register
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind fcfs_schedule_timing fcfs_chk u_fcfs_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_last_job    (req_chan.last_job),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_last_result (rsp_chan.last_result),
   .rsp_completion  (rsp_chan.completion)
);

// ----- tb/fcfs_schedule_timing_check.sv -----
`timescale 1ns / 1ps

module fcfs_schedule_timing_check (
   input  logic clock,
   input  logic reset,
   fcfs_req_if  req_mon,
   fcfs_rsp_if  rsp_mon,
   output int   fail_count,
   output int   results_due
);
   import fcfs_pkg::*;

   localparam int JOB_SLOTS = MAX_PROCESSES_DEF;

   logic [ARRIVAL_W-1:0] job_arrival [JOB_SLOTS];
   logic [BURST_W-1:0]   job_burst [JOB_SLOTS];
   int                   held_jobs;
   rsp_payload_type      service_order[$];

   // Serve the held set by earliest arrival, lowest slot on ties, and queue each result
   task automatic schedule_set();
      bit                      served [JOB_SLOTS];
      logic [COMPLETION_W-1:0] now_tick;
      logic [COMPLETION_W-1:0] arr_tick;
      logic [COMPLETION_W-1:0] bur_tick;
      logic [TOTAL_W-1:0]      tat_sum;
      logic [TOTAL_W-1:0]      wait_sum;
      int                      pick;
      rsp_payload_type         res;
      now_tick = '0;
      tat_sum  = '0;
      wait_sum = '0;
      foreach (served[j]) served[j] = 1'b0;
      for (int k = 0; k < held_jobs; k++) begin
         pick = -1;
         for (int j = 0; j < held_jobs; j++) begin
            if (!served[j] && (pick < 0 || job_arrival[j] < job_arrival[pick])) pick = j;
         end
         served[pick] = 1'b1;
         arr_tick = COMPLETION_W'(job_arrival[pick]);
         bur_tick = COMPLETION_W'(job_burst[pick]);
         // idle server jumps forward to the arrival
         if (now_tick < arr_tick) now_tick = arr_tick;
         now_tick = now_tick + bur_tick;
         res.job_index        = JOB_INDEX_W'(pick);
         res.completion       = now_tick;
         res.turnaround       = TURNAROUND_W'(now_tick - arr_tick);
         res.waiting          = WAITING_W'(now_tick - arr_tick - bur_tick);
         tat_sum              = tat_sum + TOTAL_W'(res.turnaround);
         wait_sum             = wait_sum + TOTAL_W'(res.waiting);
         res.total_turnaround = tat_sum;
         res.total_waiting    = wait_sum;
         res.last_result      = (k == held_jobs - 1);
         service_order.push_back(res);
      end
      held_jobs = 0;
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   // Track accepted jobs, predict on the last one, compare each result transaction
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         held_jobs = 0;
         service_order.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            // drop jobs beyond the store size
            if (held_jobs < JOB_SLOTS) begin
               job_arrival[held_jobs] = req_mon.arrival;
               job_burst[held_jobs]   = req_mon.burst;
               held_jobs++;
            end
            if (req_mon.last_job) schedule_set();
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (service_order.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, actual job_index %0d",
                        $time, rsp_mon.job_index);
            end else begin
               want = service_order.pop_front();
               check_field("job_index", want.job_index, rsp_mon.job_index);
               check_field("completion", want.completion, rsp_mon.completion);
               check_field("turnaround", want.turnaround, rsp_mon.turnaround);
               check_field("waiting", want.waiting, rsp_mon.waiting);
               check_field("total_turnaround", want.total_turnaround,
                           rsp_mon.total_turnaround);
               check_field("total_waiting", want.total_waiting, rsp_mon.total_waiting);
               check_field("last_result", want.last_result, rsp_mon.last_result);
            end
         end
      end
      results_due = service_order.size();
   end

endmodule

// ----- tb/fcfs_schedule_timing_tb.sv -----
`timescale 1ns / 1ps

module fcfs_schedule_timing_tb;
   import fcfs_pkg::*;

   localparam int CLK_PERIOD     = 8;
   localparam int TIMEOUT_CYCLES = 2_000_000;
   localparam int PHASE_JOBS     = 125;
   localparam int SETTLE_CYCLES  = 40;

   typedef enum logic [1:0] {
      PAT_WIDE,
      PAT_CROWDED,
      PAT_SPREAD,
      PAT_TOP
   } set_pattern_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int          fail_count;
   int          results_due;
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int          jobs_sent = 0;

   fcfs_req_if req_if ();
   fcfs_rsp_if rsp_if ();

   fcfs_schedule_timing dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   fcfs_schedule_timing_check sched_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Stall the result channel at random
   always @(negedge clock) begin
      rsp_if.ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   // Offer one job, with random idle cycles ahead of it, and hold until taken
   task automatic send_job(input logic [ARRIVAL_W-1:0] arr, input logic [BURST_W-1:0] bur,
                           input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.arrival  <= arr;
      req_if.burst    <= bur;
      req_if.last_job <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
      jobs_sent++;
   endtask

   // Send a whole set shaped by the chosen arrival pattern
   task automatic send_set(input int jobs, input set_pattern_type pat);
      logic [ARRIVAL_W-1:0] arr;
      logic [ARRIVAL_W-1:0] base;
      logic [BURST_W-1:0]   bur;
      base = ARRIVAL_W'($urandom_range(65535));
      for (int i = 0; i < jobs; i++) begin
         case (pat)
            PAT_WIDE: begin
               arr = ARRIVAL_W'($urandom_range(65535));
               bur = BURST_W'($urandom_range(65535));
            end
            PAT_CROWDED: begin
               arr = ARRIVAL_W'($urandom_range(7));
               bur = BURST_W'($urandom_range(3));
            end
            PAT_SPREAD: begin
               base = base + ARRIVAL_W'($urandom_range(40));
               arr  = base;
               bur  = BURST_W'($urandom_range(20));
            end
            default: begin
               arr = 16'hFFFF - ARRIVAL_W'($urandom_range(3));
               bur = 16'hFFFF - BURST_W'($urandom_range(255));
            end
         endcase
         send_job(arr, bur, i == jobs - 1);
      end
   endtask

   // Hold the sender until every predicted result has been taken
   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (results_due != 0) @(negedge clock);
   endtask

   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("[fcfs_schedule_timing] ERROR");
      $finish;
   end

   initial begin
      int unsigned phase_idle [4];
      int unsigned phase_stall [4];
      int          phase_start;
      int          jobs;
      phase_idle  = '{0, 53, 0, 26};
      phase_stall = '{0, 0, 53, 26};
      req_if.valid    = 1'b0;
      req_if.arrival  = '0;
      req_if.burst    = '0;
      req_if.last_job = 1'b0;
      rsp_if.ready    = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single job at the top of both ranges
      send_job(16'hFFFF, 16'hFFFF, 1'b1);
      // tied arrivals, zero bursts and an idle gap before the last job
      send_job(16'd5, 16'd0, 1'b0);
      send_job(16'd2, 16'd3, 1'b0);
      send_job(16'd5, 16'd4, 1'b0);
      send_job(16'd2, 16'd0, 1'b0);
      send_job(16'd100, 16'd1, 1'b1);
      send_job(16'd0, 16'd0, 1'b1);
      // full store of worst-case jobs, then two dropped, the second closing the set
      for (int i = 0; i < MAX_PROCESSES_DEF; i++) send_job(16'hFFFF, 16'hFFFF, 1'b0);
      send_job(16'd0, 16'd1, 1'b0);
      send_job(16'd0, 16'd2, 1'b1);
      drain_results();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = phase_idle[p];
         stall_pct     = phase_stall[p];
         phase_start   = jobs_sent;
         while (jobs_sent - phase_start < PHASE_JOBS) begin
            jobs = ($urandom_range(9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
            send_set(jobs, set_pattern_type'($urandom_range(3)));
         end
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("[fcfs_schedule_timing] OK");
      end else begin
         $display("[fcfs_schedule_timing] ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/fcfs_pkg.sv
src/fcfs_intf.sv
src/fcfs_ctrl.sv
src/fcfs_dpath.sv
src/fcfs_schedule_timing.sv
src/fcfs_chk.sv
tb/fcfs_schedule_timing_check.sv
tb/fcfs_schedule_timing_tb.sv
